// ===== rtl/rnp_pkg.sv =====
package rnp_pkg;

	localparam int MAX_PARTICLES = 65536;
	localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
	localparam int ADDR_W = 5;
	localparam int PHASE_EXCL_BIT = 26;
	localparam int STATE_W = 3;

	localparam logic [2:0] REG_ORIGIN_X = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [2:0] REG_DIR_X = 3'd3;
	localparam logic [2:0] REG_DIR_Y = 3'd4;
	localparam logic [2:0] REG_DIR_Z = 3'd5;
	localparam logic [2:0] REG_RADIUS = 3'd6;

	localparam logic signed [31:0] DIR_Z_RST = 32'sd65536;
	localparam logic [30:0] RADIUS_RST = 31'd65536;

	localparam logic [1:0] MUL_DD = 2'd0;
	localparam logic [1:0] MUL_DT = 2'd1;
	localparam logic [1:0] MUL_SQ = 2'd2;

	typedef logic signed [31:0] coord_t;

	typedef struct packed {
		coord_t [2:0] origin;
		coord_t [2:0] dir;
		logic [30:0]  radius;
	} cfg_t;

	typedef struct packed {
		logic       capture;
		logic       mul_en;
		logic [1:0] mul_sel;
		logic       t_load;
		logic       perp_load;
		logic       cmp;
		logic       publish;
	} cmd_t;

	typedef struct packed {
		logic skip;
		logic t_pos;
		logic last;
		logic out_busy;
	} sts_t;

	function automatic logic [15:0] idx16(input logic [CNT_W-1:0] c);
		logic [CNT_W+15:0] w;
		w = {16'b0, c};
		return w[15:0];
	endfunction

endpackage

// ===== rtl/rnp_regs.sv =====
module rnp_regs import rnp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t cfg_q;
	logic [2:0] reg_idx;
	logic wr_en;

	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin <= '0;
			cfg_q.dir[0] <= '0;
			cfg_q.dir[1] <= '0;
			cfg_q.dir[2] <= DIR_Z_RST;
			cfg_q.radius <= RADIUS_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_ORIGIN_X: cfg_q.origin[0] <= pwdata;
				REG_ORIGIN_Y: cfg_q.origin[1] <= pwdata;
				REG_ORIGIN_Z: cfg_q.origin[2] <= pwdata;
				REG_DIR_X:    cfg_q.dir[0] <= pwdata;
				REG_DIR_Y:    cfg_q.dir[1] <= pwdata;
				REG_DIR_Z:    cfg_q.dir[2] <= pwdata;
				REG_RADIUS:   cfg_q.radius <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_ORIGIN_X: prdata = cfg_q.origin[0];
			REG_ORIGIN_Y: prdata = cfg_q.origin[1];
			REG_ORIGIN_Z: prdata = cfg_q.origin[2];
			REG_DIR_X:    prdata = cfg_q.dir[0];
			REG_DIR_Y:    prdata = cfg_q.dir[1];
			REG_DIR_Z:    prdata = cfg_q.dir[2];
			REG_RADIUS:   prdata = {1'b0, cfg_q.radius};
			default:      prdata = '0;
		endcase
	end

endmodule

// ===== rtl/rnp_ctrl.sv =====
module rnp_ctrl import rnp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [STATE_W-1:0] S_IDLE = 3'd0;
	localparam logic [STATE_W-1:0] S_MUL1 = 3'd1;
	localparam logic [STATE_W-1:0] S_TSUM = 3'd2;
	localparam logic [STATE_W-1:0] S_MUL2 = 3'd3;
	localparam logic [STATE_W-1:0] S_PERP = 3'd4;
	localparam logic [STATE_W-1:0] S_MUL3 = 3'd5;
	localparam logic [STATE_W-1:0] S_CMP  = 3'd6;
	localparam logic [STATE_W-1:0] S_DONE = 3'd7;

	logic [STATE_W-1:0] state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd = '0;
		cmd.mul_sel = MUL_DD;
		in_stall = 1'b1;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt = sts.skip ? S_DONE : S_MUL1;
				end
			end
			S_MUL1: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_DD;
				state_nxt = S_TSUM;
			end
			S_TSUM: begin
				cmd.t_load = 1'b1;
				state_nxt = sts.t_pos ? S_MUL2 : S_DONE;
			end
			S_MUL2: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_DT;
				state_nxt = S_PERP;
			end
			S_PERP: begin
				cmd.perp_load = 1'b1;
				state_nxt = S_MUL3;
			end
			S_MUL3: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_SQ;
				state_nxt = S_CMP;
			end
			S_CMP: begin
				cmd.cmp = 1'b1;
				state_nxt = S_DONE;
			end
			S_DONE: begin
				if (!sts.last) begin
					state_nxt = S_IDLE;
				end else if (!sts.out_busy) begin
					cmd.publish = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/rnp_dp.sv =====
module rnp_dp import rnp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic [31:0]        phase_word,
	input  logic               last_item,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               found,
	output logic [15:0]        hit_index,
	output logic               overflow
);

	localparam logic signed [51:0] T_HI = 52'sd2147483647;
	localparam logic signed [51:0] T_LO = -52'sd2147483648;

	coord_t pos_v [3];
	logic signed [32:0] delta_q [3];
	logic signed [65:0] prod_q [3];
	logic signed [32:0] op_a [3];
	logic signed [32:0] op_b [3];
	logic [31:0] mag_q [3];
	logic [2:0] sat_q;
	logic signed [31:0] t_q;
	logic last_q;
	logic [15:0] idx_q;
	logic [61:0] rsq_q;

	logic [CNT_W-1:0] count_q;
	logic have_best_q;
	logic signed [31:0] best_t_q;
	logic [15:0] best_idx_q;
	logic ovf_seen_q;
	logic out_valid_q;
	logic found_q;
	logic [15:0] hit_idx_q;
	logic ovf_q;

	logic over_limit;
	logic signed [51:0] t_sum;
	logic signed [31:0] t_sat;
	logic signed [50:0] perp [3];
	logic [50:0] perp_mag [3];
	logic [49:0] dsq;
	logic hit;

	assign pos_v[0] = pos_x;
	assign pos_v[1] = pos_y;
	assign pos_v[2] = pos_z;

	assign over_limit = count_q >= CNT_W'(MAX_PARTICLES);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			case (cmd.mul_sel)
				MUL_DD: begin
					op_a[i] = delta_q[i];
					op_b[i] = {cfg.dir[i][31], cfg.dir[i]};
				end
				MUL_DT: begin
					op_a[i] = {cfg.dir[i][31], cfg.dir[i]};
					op_b[i] = {t_q[31], t_q};
				end
				MUL_SQ: begin
					op_a[i] = {1'b0, mag_q[i]};
					op_b[i] = {1'b0, mag_q[i]};
				end
				default: begin
					op_a[i] = '0;
					op_b[i] = '0;
				end
			endcase
			perp[i] = delta_q[i] - $signed(prod_q[i][65:16]);
			perp_mag[i] = perp[i][50] ? 51'(-perp[i]) : 51'(perp[i]);
		end
	end

	always_comb begin
		t_sum = $signed(prod_q[0][65:16]) + $signed(prod_q[1][65:16])
			+ $signed(prod_q[2][65:16]);
		if (t_sum > T_HI) begin
			t_sat = T_HI[31:0];
		end else if (t_sum < T_LO) begin
			t_sat = T_LO[31:0];
		end else begin
			t_sat = t_sum[31:0];
		end
	end

	assign dsq = {2'b0, prod_q[0][63:16]} + {2'b0, prod_q[1][63:16]}
		+ {2'b0, prod_q[2][63:16]};
	assign hit = !(|sat_q) && (dsq < {4'b0, rsq_q[61:16]});

	assign sts.skip = phase_word[PHASE_EXCL_BIT] || over_limit;
	assign sts.t_pos = t_sat > 32'sd0;
	assign sts.last = last_q;
	assign sts.out_busy = out_valid_q && out_stall;

	always_ff @(posedge clk) begin
		rsq_q <= cfg.radius * cfg.radius;
		if (cmd.capture) begin
			for (int i = 0; i < 3; i++) begin
				delta_q[i] <= {pos_v[i][31], pos_v[i]} - {cfg.origin[i][31], cfg.origin[i]};
			end
			last_q <= last_item;
			idx_q <= idx16(count_q);
		end
		if (cmd.mul_en) begin
			for (int i = 0; i < 3; i++) begin
				prod_q[i] <= op_a[i] * op_b[i];
			end
		end
		if (cmd.t_load) begin
			t_q <= t_sat;
		end
		if (cmd.perp_load) begin
			for (int i = 0; i < 3; i++) begin
				mag_q[i] <= perp_mag[i][31:0];
				sat_q[i] <= |perp_mag[i][50:32];
			end
		end
		if (cmd.publish) begin
			found_q <= have_best_q;
			hit_idx_q <= have_best_q ? best_idx_q : 16'd0;
			ovf_q <= ovf_seen_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			have_best_q <= 1'b0;
			best_t_q <= '0;
			best_idx_q <= '0;
			ovf_seen_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				if (over_limit) begin
					ovf_seen_q <= 1'b1;
				end else begin
					count_q <= count_q + 1'b1;
				end
			end
			if (cmd.cmp && hit && (!have_best_q || t_q < best_t_q)) begin
				have_best_q <= 1'b1;
				best_t_q <= t_q;
				best_idx_q <= idx_q;
			end
			if (cmd.publish) begin
				count_q <= '0;
				have_best_q <= 1'b0;
				best_t_q <= '0;
				best_idx_q <= '0;
				ovf_seen_q <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign found = found_q;
	assign hit_index = hit_idx_q;
	assign overflow = ovf_q;

endmodule

// ===== rtl/ray_nearest_particle_pick.sv =====
// channel  valid     stall      payload
// input    in_valid  in_stall   pos_x pos_y pos_z phase_word last_item
// output   out_valid out_stall  found hit_index overflow
// config   APB       pready=1   paddr 4*i, pwdata, prdata
//
// A tested item makes three passes through the three axis multipliers
// (projection, foot point, squared distance). An item with t <= 0 stops after the
// first pass, an excluded or over-limit item skips the multipliers.
// arst_n restores the register reset values and clears the set state.
// in_stall is high while an item is in work; a last item waits while the previous
// result is still stalled at the output.
module ray_nearest_particle_pick import rnp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic [31:0]        phase_word,
	input  logic               last_item,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               found,
	output logic [15:0]        hit_index,
	output logic               overflow
);

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	rnp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rnp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	rnp_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cmd        (cmd),
		.sts        (sts),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.phase_word (phase_word),
		.last_item  (last_item),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.found      (found),
		.hit_index  (hit_index),
		.overflow   (overflow)
	);

`ifndef SYNTHESIS
	a_publish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> !(out_valid && out_stall))
		else $error("result published over a stalled transaction");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken again right after a transaction");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.publish))
		else $error("output valid without a publish");
`endif

endmodule

// ===== tb/tb_ray_nearest_particle_pick.sv =====
`timescale 1ns / 1ps

module tb_ray_nearest_particle_pick;
	import rnp_pkg::*;

	typedef struct packed {
		coord_t      x;
		coord_t      y;
		coord_t      z;
		logic [31:0] phase;
		logic        last;
	} particle_t;

	typedef struct packed {
		logic        found;
		logic [15:0] idx;
		logic        ovf;
	} pick_t;

	typedef struct packed {
		particle_t p;
		logic      typed;
		pick_t     want;
	} row_t;

	localparam coord_t Q1 = 32'sd65536;
	localparam coord_t CMIN = 32'sh8000_0000;
	localparam coord_t CMAX = 32'sh7FFF_FFFF;
	localparam logic [31:0] EXCL_PHASE = 32'd1 << PHASE_EXCL_BIT;
	localparam longint T_MAX = 64'sd2147483647;
	localparam longint T_MIN = -64'sd2147483648;
	localparam logic [2:0] REG_ORDER [7] = '{REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z,
		REG_DIR_X, REG_DIR_Y, REG_DIR_Z, REG_RADIUS};
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 138;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [ADDR_W-1:0]  paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_stall;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic [31:0]        phase_word;
	logic               last_item;
	logic               out_valid;
	logic               out_stall;
	logic               found;
	logic [15:0]        hit_index;
	logic               overflow;

	ray_nearest_particle_pick dut (.*);

	always #5 clk = ~clk;

	coord_t      ray_org [3];
	coord_t      ray_dir [3];
	logic [30:0] ray_rad;

	logic   have_best;
	longint best_t;
	int     best_idx;
	int     set_count;
	logic   set_ovf;

	pick_t pick_q [$];
	pick_t chk_want;
	logic  idle_en;
	int    n_err;
	int    n_items;
	int    n_sets;
	int    n_found;
	int    n_ovf;
	int    n_cfg;

	row_t stim_tab [17] = '{
		'{'{32'sd0, 32'sd0, Q1, 32'd0, 1'b1}, 1'b1, '{1'b1, 16'd0, 1'b0}},
		'{'{32'sd0, 32'sd0, 32'sd0, 32'd0, 1'b1}, 1'b1, '{1'b0, 16'd0, 1'b0}},
		'{'{32'sd0, 32'sd0, -32'sd1, 32'd0, 1'b1}, 1'b1, '{1'b0, 16'd0, 1'b0}},
		'{'{32'sd0, 32'sd0, 3 * Q1, 32'd0, 1'b0}, 1'b0, '{1'b0, 16'd0, 1'b0}},
		'{'{32'sd0, 32'sd0, 2 * Q1, 32'd0, 1'b0}, 1'b0, '{1'b0, 16'd0, 1'b0}},
		'{'{32'sd0, 32'sd0, 2 * Q1, 32'd0, 1'b1}, 1'b1, '{1'b1, 16'd1, 1'b0}},
		'{'{32'sd0, 32'sd0, Q1, EXCL_PHASE, 1'b1}, 1'b1, '{1'b0, 16'd0, 1'b0}},
		'{'{32'sd0, 32'sd0, Q1, 32'd0, 1'b0}, 1'b0, '{1'b0, 16'd0, 1'b0}},
		'{'{32'sd0, 32'sd0, 2 * Q1, 32'hFFFF_FFFF, 1'b1}, 1'b1, '{1'b1, 16'd0, 1'b0}},
		'{'{Q1, 32'sd0, Q1, 32'd0, 1'b1}, 1'b1, '{1'b0, 16'd0, 1'b0}},
		'{'{Q1 - 1, 32'sd0, Q1, 32'hFBFF_FFFF, 1'b1}, 1'b1, '{1'b1, 16'd0, 1'b0}},
		'{'{CMAX, CMAX, CMAX, 32'd0, 1'b1}, 1'b1, '{1'b0, 16'd0, 1'b0}},
		'{'{32'sd0, 32'sd0, CMAX, 32'd0, 1'b1}, 1'b1, '{1'b1, 16'd0, 1'b0}},
		'{'{CMIN, CMIN, CMIN, 32'd0, 1'b1}, 1'b1, '{1'b0, 16'd0, 1'b0}},
		'{'{CMIN, CMAX, Q1, 32'd0, 1'b0}, 1'b0, '{1'b0, 16'd0, 1'b0}},
		'{'{32'sd0, 32'shFFFF_0001, 5 * Q1, 32'd0, 1'b0}, 1'b0, '{1'b0, 16'd0, 1'b0}},
		'{'{32'sd0, 32'sd0, 4 * Q1, 32'd0, 1'b1}, 1'b0, '{1'b0, 16'd0, 1'b0}}
	};

	function automatic logic [63:0] sq_q16(input longint v);
		logic [63:0] m;
		m = (v < 0) ? -v : v;
		if (m[63:32] != 32'd0)
			return '1;
		return (m * m) >> 16;
	endfunction

	function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? '1 : s[63:0];
	endfunction

	function automatic logic predict_pick(input particle_t p, output pick_t r);
		coord_t      c [3];
		longint      d [3];
		longint      t;
		longint      perp;
		logic [63:0] dsq;
		logic [63:0] rsq;
		int          idx;
		int          i;
		r = '0;
		c = '{p.x, p.y, p.z};
		if (set_count >= MAX_PARTICLES) begin
			set_ovf = 1'b1;
		end else begin
			idx = set_count;
			set_count++;
			if (!p.phase[PHASE_EXCL_BIT]) begin
				t = 0;
				for (i = 0; i < 3; i++) begin
					d[i] = longint'(c[i]) - longint'(ray_org[i]);
					t += (d[i] * longint'(ray_dir[i])) >>> 16;
				end
				if (t > T_MAX)
					t = T_MAX;
				if (t < T_MIN)
					t = T_MIN;
				if (t > 0) begin
					dsq = '0;
					for (i = 0; i < 3; i++) begin
						perp = d[i] - ((longint'(ray_dir[i]) * t) >>> 16);
						dsq = sat_add64(dsq, sq_q16(perp));
					end
					rsq = (64'(ray_rad) * 64'(ray_rad)) >> 16;
					if (dsq < rsq && (!have_best || t < best_t)) begin
						have_best = 1'b1;
						best_t = t;
						best_idx = idx;
					end
				end
			end
		end
		if (!p.last)
			return 1'b0;
		r.found = have_best;
		r.idx = have_best ? best_idx[15:0] : 16'd0;
		r.ovf = set_ovf;
		have_best = 1'b0;
		best_t = 0;
		best_idx = 0;
		set_count = 0;
		set_ovf = 1'b0;
		return 1'b1;
	endfunction

	function automatic particle_t gen_particle(input particle_t prev);
		particle_t p;
		coord_t    c [3];
		coord_t    picks [5];
		longint    s;
		longint    v;
		int        sel;
		int        i;
		picks = '{CMIN, CMAX, 32'sd0, -32'sd1, Q1};
		sel = $urandom_range(0, 99);
		s = longint'($urandom_range(0, 16 << 16)) - 65536;
		for (i = 0; i < 3; i++) begin
			if (sel < 60) begin
				v = longint'(ray_org[i]) + ((longint'(ray_dir[i]) * s) >>> 16)
					+ ((longint'($urandom_range(0, 1 << 18)) - (1 << 17)) >>> $urandom_range(0, 10));
				c[i] = coord_t'(v);
			end else if (sel < 80) begin
				c[i] = $urandom;
			end else begin
				c[i] = picks[$urandom_range(0, 4)];
			end
		end
		p.x = c[0];
		p.y = c[1];
		p.z = c[2];
		if (sel >= 90) begin
			p.x = prev.x;
			p.y = prev.y;
			p.z = prev.z;
		end
		p.phase = $urandom_range(0, 1) ? 32'd0 : $urandom;
		p.phase[PHASE_EXCL_BIT] = ($urandom_range(0, 3) == 0);
		p.last = ($urandom_range(0, 7) == 0);
		return p;
	endfunction

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_ORIGIN_X: ray_org[0] = val;
			REG_ORIGIN_Y: ray_org[1] = val;
			REG_ORIGIN_Z: ray_org[2] = val;
			REG_DIR_X:    ray_dir[0] = val;
			REG_DIR_Y:    ray_dir[1] = val;
			REG_DIR_Z:    ray_dir[2] = val;
			REG_RADIUS:   ray_rad = val[30:0];
			default: ;
		endcase
	endtask

	task automatic load_ray(input int mode);
		logic [31:0] v [7];
		int          i;
		case (mode)
			0: begin
				v = '{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 32'hFFFF_FFFF};
			end
			1: begin
				v = '{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 32'h0000_0000};
			end
			2: begin
				for (i = 0; i < 7; i++)
					v[i] = $urandom;
			end
			default: begin
				for (i = 0; i < 3; i++) begin
					v[i] = $urandom_range(0, 33554431) - 32'd16777216;
					v[i + 3] = $urandom_range(0, 4 << 16) - (32'd2 << 16);
				end
				v[6] = $urandom_range(0, 8 << 16);
			end
		endcase
		for (i = 0; i < 7; i++)
			reg_write(REG_ORDER[i], v[i]);
		n_cfg++;
	endtask

	task automatic send_particle(input particle_t p, input logic use_typed, input pick_t typed);
		int    gap;
		pick_t r;
		gap = idle_en ? $urandom_range(0, 16) : 0;
		repeat (gap) @(negedge clk) in_valid <= 1'b0;
		@(negedge clk);
		pos_x <= p.x;
		pos_y <= p.y;
		pos_z <= p.z;
		phase_word <= p.phase;
		last_item <= p.last;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		n_items++;
		if (predict_pick(p, r))
			pick_q.push_back(use_typed ? typed : r);
	endtask

	task automatic drain();
		@(negedge clk) in_valid <= 1'b0;
		while (pick_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pick_q.size() == 0) begin
				$error("unexpected result: found=%0d hit_index=%0d overflow=%0d",
					found, hit_index, overflow);
				n_err++;
			end else begin
				chk_want = pick_q.pop_front();
				n_sets++;
				n_found += chk_want.found;
				n_ovf += chk_want.ovf;
				if (found !== chk_want.found) begin
					$error("found: expected %0d, got %0d", chk_want.found, found);
					n_err++;
				end
				if (hit_index !== chk_want.idx) begin
					$error("hit_index: expected %0d, got %0d", chk_want.idx, hit_index);
					n_err++;
				end
				if (overflow !== chk_want.ovf) begin
					$error("overflow: expected %0d, got %0d", chk_want.ovf, overflow);
					n_err++;
				end
			end
		end
	end

	initial begin
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			n = idle_en ? $urandom_range(0, 16) : 0;
			repeat (n) @(negedge clk) out_stall <= 1'b1;
			@(negedge clk) out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	initial begin
		#15_000_000;
		$display("tb_ray_nearest_particle_pick: done, errors");
		$finish;
	end

	initial begin
		particle_t p;
		particle_t prev;
		int        ph;
		int        k;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		phase_word = '0;
		last_item = 1'b0;
		idle_en = 1'b1;
		ray_org = '{32'sd0, 32'sd0, 32'sd0};
		ray_dir = '{32'sd0, 32'sd0, DIR_Z_RST};
		ray_rad = RADIUS_RST;
		have_best = 1'b0;
		best_t = 0;
		best_idx = 0;
		set_count = 0;
		set_ovf = 1'b0;
		n_err = 0;
		n_items = 0;
		n_sets = 0;
		n_found = 0;
		n_ovf = 0;
		n_cfg = 0;
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		for (k = 0; k < 17; k++)
			send_particle(stim_tab[k].p, stim_tab[k].typed, stim_tab[k].want);
		drain();

		// one set past the particle limit, the last counted slot holds the hit
		idle_en = 1'b0;
		for (k = 0; k <= MAX_PARTICLES; k++) begin
			p.x = $urandom;
			p.y = $urandom;
			p.z = $urandom;
			p.phase = $urandom | EXCL_PHASE;
			p.last = (k == MAX_PARTICLES);
			if (k % 4096 == 100)
				p = '{32'sd0, 32'sd0, -Q1, 32'd0, 1'b0};
			if (k == MAX_PARTICLES - 1)
				p = '{32'sd0, 32'sd0, Q1, 32'd0, 1'b0};
			if (k == MAX_PARTICLES)
				p = '{32'sd0, 32'sd0, Q1 >>> 1, 32'd0, 1'b1};
			send_particle(p, 1'b0, '0);
		end
		drain();

		for (ph = 0; ph < PHASES; ph++) begin
			idle_en = (ph != 3);
			load_ray(ph < 3 ? ph : 3);
			prev = '0;
			for (k = 0; k < PHASE_ITEMS; k++) begin
				p = gen_particle(prev);
				if (k == PHASE_ITEMS - 1)
					p.last = 1'b1;
				send_particle(p, 1'b0, '0);
				prev = p;
			end
			drain();
		end

		$display("covered %0d particles in %0d sets under %0d ray settings",
			n_items, n_sets, n_cfg + 1);
		$display("%0d sets picked a particle, %0d sets overflowed", n_found, n_ovf);
		if (n_err == 0)
			$display("tb_ray_nearest_particle_pick: done, clean");
		else
			$display("tb_ray_nearest_particle_pick: done, errors");
		$finish;
	end

endmodule
